// ===== rtl/wlc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and character helpers for the wildcard line comparator.
// No dependencies.
package wlc_pkg;

  localparam int MaxLine = 256;
  localparam int AddrW   = $clog2(MaxLine);
  localparam int LenW    = $clog2(MaxLine + 1);
  localparam int OutIdxW = $clog2(2 * MaxLine + 2);
  localparam int CpW     = 21;
  localparam int FuncW   = 2;
  localparam int CfgW    = 6;

  localparam logic [FuncW-1:0] FuncAppendOut = 2'd0;
  localparam logic [FuncW-1:0] FuncAppendRef = 2'd1;
  localparam logic [FuncW-1:0] FuncCompare   = 2'd2;

  localparam logic [CfgW-1:0] CrDigitReset = 6'd48;

  localparam logic [CpW-1:0] CpNul     = 21'h000000;
  localparam logic [CpW-1:0] CpSpace   = 21'h000020;
  localparam logic [CpW-1:0] CpPlus    = 21'h00002B;
  localparam logic [CpW-1:0] CpMinus   = 21'h00002D;
  localparam logic [CpW-1:0] CpDot     = 21'h00002E;
  localparam logic [CpW-1:0] CpZero    = 21'h000030;
  localparam logic [CpW-1:0] CpNine    = 21'h000039;
  localparam logic [CpW-1:0] CpUpperE  = 21'h000045;
  localparam logic [CpW-1:0] CpUpperJ  = 21'h00004A;
  localparam logic [CpW-1:0] CpLowerM  = 21'h00006D;
  localparam logic [CpW-1:0] CpLowerN  = 21'h00006E;
  localparam logic [CpW-1:0] CpLowerU  = 21'h000075;
  localparam logic [CpW-1:0] CpOverbar = 21'h0000AF;
  localparam logic [CpW-1:0] CpMu      = 21'h0003BC;

  localparam logic [CpW-1:0] WcDigits  = 21'h002070;
  localparam logic [CpW-1:0] WcSpaces  = 21'h0000B9;
  localparam logic [CpW-1:0] WcReal    = 21'h0000B2;
  localparam logic [CpW-1:0] WcAny     = 21'h0000B3;
  localparam logic [CpW-1:0] WcOverbar = 21'h002074;
  localparam logic [CpW-1:0] WcSign    = 21'h002075;
  localparam logic [CpW-1:0] WcCrDigit = 21'h002076;
  localparam logic [CpW-1:0] WcUnit    = 21'h00207F;

  typedef struct packed {
    logic            done;
    logic            diff;
    logic [LenW-1:0] pos;
  } walk_res_t;

  function automatic logic is_dig(logic [CpW-1:0] c);
    return (c >= CpZero) && (c <= CpNine);
  endfunction

  function automatic logic is_real_char(logic [CpW-1:0] c);
    return is_dig(c) || (c == CpOverbar) || (c == CpUpperE) || (c == CpUpperJ) ||
           (c == CpDot);
  endfunction

endpackage

// ===== rtl/wlc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wlc_walker.sv =====
`timescale 1ns / 1ps
// Compare sequencer: walks the reference and output line memories one step a cycle.
// Depends on wlc_pkg.
module wlc_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wlc_pkg::LenW-1:0]    out_len_i,
  input  logic [wlc_pkg::LenW-1:0]    ref_len_i,
  input  logic [wlc_pkg::CfgW-1:0]    cr_digit_i,
  input  logic [wlc_pkg::CpW-1:0]     out_rdata_i,
  input  logic [wlc_pkg::CpW-1:0]     ref_rdata_i,
  output logic [wlc_pkg::AddrW-1:0]   out_raddr_o,
  output logic [wlc_pkg::AddrW-1:0]   ref_raddr_o,
  output logic                        busy_o,
  output wlc_pkg::walk_res_t          res_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StRun
  } state_e;

  typedef enum logic [1:0] {
    RunDigits,
    RunSpaces,
    RunReal
  } run_kind_e;

  state_e                        state_q, state_d;
  run_kind_e                     kind_q, kind_d;
  logic [wlc_pkg::OutIdxW-1:0]   ai_q, ai_d;
  logic [wlc_pkg::LenW-1:0]      pos_q, pos_d;
  logic [wlc_pkg::CpW-1:0]       a_cp;
  logic [wlc_pkg::CpW-1:0]       r_cp;
  logic [wlc_pkg::CpW-1:0]       cr_cp;
  logic                          run_hit;
  wlc_pkg::walk_res_t            res;

  assign a_cp  = (ai_q < wlc_pkg::OutIdxW'(out_len_i)) ? out_rdata_i : wlc_pkg::CpNul;
  assign r_cp  = (pos_q < ref_len_i) ? ref_rdata_i : wlc_pkg::CpNul;
  assign cr_cp = wlc_pkg::CpW'(cr_digit_i);

  always_comb begin
    case (kind_q)
      RunDigits: run_hit = wlc_pkg::is_dig(a_cp);
      RunSpaces: run_hit = (a_cp == wlc_pkg::CpSpace);
      RunReal:   run_hit = wlc_pkg::is_real_char(a_cp);
      default:   run_hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    ai_d     = ai_q;
    pos_d    = pos_q;
    res.done = 1'b0;
    res.diff = 1'b0;
    res.pos  = pos_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ai_d    = '0;
          pos_d   = '0;
          state_d = StEval;
        end
      end
      StEval: begin
        ai_d  = ai_q + 1'b1;
        pos_d = pos_q + 1'b1;
        if (a_cp == r_cp) begin
          if (a_cp == wlc_pkg::CpNul) begin
            res.done = 1'b1;
          end
        end else begin
          case (r_cp)
            wlc_pkg::WcDigits: begin
              res.done = !wlc_pkg::is_dig(a_cp);
              res.diff = res.done;
              kind_d   = RunDigits;
              pos_d    = pos_q;
              state_d  = StRun;
            end
            wlc_pkg::WcSpaces: begin
              res.done = (a_cp != wlc_pkg::CpSpace);
              res.diff = res.done;
              kind_d   = RunSpaces;
              pos_d    = pos_q;
              state_d  = StRun;
            end
            wlc_pkg::WcReal: begin
              res.done = !wlc_pkg::is_real_char(a_cp);
              res.diff = res.done;
              kind_d   = RunReal;
              pos_d    = pos_q;
              state_d  = StRun;
            end
            wlc_pkg::WcAny: begin
              res.done = 1'b1;
            end
            wlc_pkg::WcOverbar: begin
              if (a_cp != wlc_pkg::CpOverbar) begin
                ai_d = ai_q;
              end
            end
            wlc_pkg::WcSign: begin
              res.done = (a_cp != wlc_pkg::CpPlus) && (a_cp != wlc_pkg::CpMinus);
              res.diff = res.done;
            end
            wlc_pkg::WcCrDigit: begin
              res.done = (a_cp != cr_cp);
              res.diff = res.done;
            end
            wlc_pkg::WcUnit: begin
              if ((a_cp != wlc_pkg::CpLowerM) && (a_cp != wlc_pkg::CpLowerN) &&
                  (a_cp != wlc_pkg::CpLowerU) && (a_cp != wlc_pkg::CpMu)) begin
                ai_d = ai_q;
              end
            end
            default: begin
              res.done = 1'b1;
              res.diff = 1'b1;
            end
          endcase
        end
        if (res.done) begin
          state_d = StIdle;
        end
      end
      StRun: begin
        if (run_hit) begin
          ai_d = ai_q + 1'b1;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = StEval;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kind_q  <= RunDigits;
      ai_q    <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      ai_q    <= ai_d;
      pos_q   <= pos_d;
    end
  end

  // next indices address the memories so data lines up with the indices
  assign out_raddr_o = ai_d[wlc_pkg::AddrW-1:0];
  assign ref_raddr_o = pos_d[wlc_pkg::AddrW-1:0];
  assign busy_o      = (state_q != StIdle);
  assign res_o       = res;

endmodule

// ===== rtl/wildcard_line_comparator_top.sv =====
`timescale 1ns / 1ps
// Top level of the wildcard line comparator: line memories, lengths, config and result.
// Depends on wlc_pkg, wlc_ram and wlc_walker.
//
// Use: a transaction is taken when start is high and busy is low. func_i selects
// append to the output line, append to the reference line, or compare and clear;
// code_point_i is the appended character. Appends never raise busy, so while no
// compare is running one may follow every cycle. A code point appended to a full line
// is dropped and the overflow flag is set.
// A compare raises busy while the walker steps through both line memories, one
// reference or output character per cycle; then done_o pulses for one cycle with
// different_o, mismatch_pos_o and overflowed_o. busy drops in that same cycle, so
// the next transaction may start alongside the result.
// The receiver cannot stall; results are valid only while done_o is high.
// cfg_we_i / cfg_wdata_i write the expected fixed-result digit; write only while idle.
// Reset clears both line lengths, the overflow flag and the walker; the digit
// register returns to '0'. Line memory contents are not cleared.
module wildcard_line_comparator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [wlc_pkg::FuncW-1:0]   func_i,
  input  logic [wlc_pkg::CpW-1:0]     code_point_i,
  input  logic                        cfg_we_i,
  input  logic [wlc_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic                        different_o,
  output logic [wlc_pkg::LenW-1:0]    mismatch_pos_o,
  output logic                        overflowed_o
);

  logic [wlc_pkg::LenW-1:0]  out_len_q, out_len_d;
  logic [wlc_pkg::LenW-1:0]  ref_len_q, ref_len_d;
  logic                      ovf_q, ovf_d;
  logic [wlc_pkg::CfgW-1:0]  cr_digit_q;
  logic                      done_q;
  logic                      diff_q;
  logic [wlc_pkg::LenW-1:0]  pos_q;
  logic                      ovf_out_q;

  logic                      accept;
  logic                      out_full;
  logic                      ref_full;
  logic                      out_we;
  logic                      ref_we;
  logic                      walk_start;
  logic                      walk_busy;
  logic                      final_diff;
  logic [wlc_pkg::AddrW-1:0] out_raddr;
  logic [wlc_pkg::AddrW-1:0] ref_raddr;
  logic [wlc_pkg::CpW-1:0]   out_rdata;
  logic [wlc_pkg::CpW-1:0]   ref_rdata;
  wlc_pkg::walk_res_t        walk_res;

  assign accept     = start && !walk_busy;
  assign out_full   = (out_len_q == wlc_pkg::LenW'(wlc_pkg::MaxLine));
  assign ref_full   = (ref_len_q == wlc_pkg::LenW'(wlc_pkg::MaxLine));
  assign out_we     = accept && (func_i == wlc_pkg::FuncAppendOut) && !out_full;
  assign ref_we     = accept && (func_i == wlc_pkg::FuncAppendRef) && !ref_full;
  assign walk_start = accept && (func_i == wlc_pkg::FuncCompare);
  assign final_diff = walk_res.diff || ovf_q;

  always_comb begin
    out_len_d = out_len_q;
    ref_len_d = ref_len_q;
    ovf_d     = ovf_q;
    if (walk_res.done) begin
      out_len_d = '0;
      ref_len_d = '0;
      ovf_d     = 1'b0;
    end else if (accept) begin
      case (func_i)
        wlc_pkg::FuncAppendOut: begin
          if (out_full) begin
            ovf_d = 1'b1;
          end else begin
            out_len_d = out_len_q + 1'b1;
          end
        end
        wlc_pkg::FuncAppendRef: begin
          if (ref_full) begin
            ovf_d = 1'b1;
          end else begin
            ref_len_d = ref_len_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q  <= '0;
      ref_len_q  <= '0;
      ovf_q      <= 1'b0;
      cr_digit_q <= wlc_pkg::CrDigitReset;
      done_q     <= 1'b0;
    end else begin
      out_len_q <= out_len_d;
      ref_len_q <= ref_len_d;
      ovf_q     <= ovf_d;
      done_q    <= walk_res.done;
      if (cfg_we_i) begin
        cr_digit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_res.done) begin
      diff_q    <= final_diff;
      pos_q     <= final_diff ? walk_res.pos : '0;
      ovf_out_q <= ovf_q;
    end
  end

  wlc_ram #(
    .Width (wlc_pkg::CpW),
    .Depth (wlc_pkg::MaxLine)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_len_q[wlc_pkg::AddrW-1:0]),
    .wdata_i (code_point_i),
    .raddr_i (out_raddr),
    .rdata_o (out_rdata)
  );

  wlc_ram #(
    .Width (wlc_pkg::CpW),
    .Depth (wlc_pkg::MaxLine)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_len_q[wlc_pkg::AddrW-1:0]),
    .wdata_i (code_point_i),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  wlc_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (walk_start),
    .out_len_i   (out_len_q),
    .ref_len_i   (ref_len_q),
    .cr_digit_i  (cr_digit_q),
    .out_rdata_i (out_rdata),
    .ref_rdata_i (ref_rdata),
    .out_raddr_o (out_raddr),
    .ref_raddr_o (ref_raddr),
    .busy_o      (walk_busy),
    .res_o       (walk_res)
  );

  assign busy           = walk_busy;
  assign done_o         = done_q;
  assign different_o    = diff_q;
  assign mismatch_pos_o = pos_q;
  assign overflowed_o   = ovf_out_q;

endmodule

// ===== tb/wildcard_line_comparator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_line_comparator_top: loads output and reference
// lines, runs compares and checks each result against a built-in line matcher.
// Depends on wlc_pkg and the comparator RTL.
module wildcard_line_comparator_top_test;

  typedef logic [wlc_pkg::CpW-1:0] cp_t;

  typedef struct {
    logic                     diff;
    logic [wlc_pkg::LenW-1:0] pos;
    logic                     ovf;
  } verdict_t;

  localparam logic [wlc_pkg::FuncW-1:0] FuncIgnored = 2'd3;
  localparam int CycleLimit = 600000;

  localparam cp_t CpA     = 21'h61;
  localparam cp_t CpB     = 21'h62;
  localparam cp_t CpQ     = 21'h71;
  localparam cp_t CpX     = 21'h78;
  localparam cp_t CpY     = 21'h79;
  localparam cp_t CpOne   = 21'h31;
  localparam cp_t CpTwo   = 21'h32;
  localparam cp_t CpThree = 21'h33;
  localparam cp_t CpFive  = 21'h35;
  localparam cp_t CpTop   = 21'h10FFFF;
  localparam cp_t CpHiMid = 21'h0F0000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [wlc_pkg::FuncW-1:0]   func_i;
  cp_t                         code_point_i;
  logic                        cfg_we_i;
  logic [wlc_pkg::CfgW-1:0]    cfg_wdata_i;
  logic                        done_o;
  logic                        different_o;
  logic [wlc_pkg::LenW-1:0]    mismatch_pos_o;
  logic                        overflowed_o;

  // matcher state
  cp_t                      out_chars [wlc_pkg::MaxLine];
  cp_t                      ref_chars [wlc_pkg::MaxLine];
  int                       out_cnt;
  int                       ref_cnt;
  logic                     ovf_flag;
  logic [wlc_pkg::CfgW-1:0] cr_digit;

  verdict_t verdict_q [$];
  verdict_t got_exp;
  cp_t      out_seq [$];
  cp_t      ref_seq [$];

  int idle_pct;
  int items_sent;
  int results_seen;
  int errors;
  int cycles = 0;

  wildcard_line_comparator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .code_point_i   (code_point_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .different_o    (different_o),
    .mismatch_pos_o (mismatch_pos_o),
    .overflowed_o   (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, verdict_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected compare result: diff %0d pos %0d ovf %0d", $time,
                 different_o, mismatch_pos_o, overflowed_o);
        errors++;
      end else begin
        got_exp = verdict_q.pop_front();
        results_seen++;
        if (different_o !== got_exp.diff) begin
          $display("%0t different mismatch: expected %0d, actual %0d", $time,
                   got_exp.diff, different_o);
          errors++;
        end
        if (mismatch_pos_o !== got_exp.pos) begin
          $display("%0t mismatch_pos mismatch: expected %0d, actual %0d", $time,
                   got_exp.pos, mismatch_pos_o);
          errors++;
        end
        if (overflowed_o !== got_exp.ovf) begin
          $display("%0t overflowed mismatch: expected %0d, actual %0d", $time,
                   got_exp.ovf, overflowed_o);
          errors++;
        end
      end
    end
  end

  function automatic cp_t out_at(int i);
    return (i < out_cnt) ? out_chars[i] : wlc_pkg::CpNul;
  endfunction

  function automatic cp_t ref_at(int i);
    return (i < ref_cnt) ? ref_chars[i] : wlc_pkg::CpNul;
  endfunction

  function automatic logic digit_cp(cp_t c);
    return c >= wlc_pkg::CpZero && c <= wlc_pkg::CpNine;
  endfunction

  function automatic logic number_cp(cp_t c);
    return digit_cp(c) || c == wlc_pkg::CpOverbar || c == wlc_pkg::CpUpperE ||
           c == wlc_pkg::CpUpperJ || c == wlc_pkg::CpDot;
  endfunction

  // greedy walk of the reference pattern over the output line
  function automatic verdict_t match_lines();
    verdict_t v;
    int       oi;
    int       p;
    cp_t      a;
    cp_t      r;
    logic     stop;
    oi = 0;
    p = 0;
    v.diff = 1'b0;
    stop = 1'b0;
    while (!stop) begin
      a = out_at(oi);
      r = ref_at(p);
      oi++;
      if (a == r) begin
        if (a == wlc_pkg::CpNul) stop = 1'b1;
      end else begin
        case (r)
          wlc_pkg::WcDigits: begin
            if (!digit_cp(a)) begin
              v.diff = 1'b1;
              stop = 1'b1;
            end else begin
              while (digit_cp(out_at(oi))) oi++;
            end
          end
          wlc_pkg::WcSpaces: begin
            if (a != wlc_pkg::CpSpace) begin
              v.diff = 1'b1;
              stop = 1'b1;
            end else begin
              while (out_at(oi) == wlc_pkg::CpSpace) oi++;
            end
          end
          wlc_pkg::WcReal: begin
            if (!number_cp(a)) begin
              v.diff = 1'b1;
              stop = 1'b1;
            end else begin
              while (number_cp(out_at(oi))) oi++;
            end
          end
          wlc_pkg::WcAny: stop = 1'b1;
          wlc_pkg::WcOverbar: begin
            if (a != wlc_pkg::CpOverbar) oi--;
          end
          wlc_pkg::WcSign: begin
            if (a != wlc_pkg::CpPlus && a != wlc_pkg::CpMinus) begin
              v.diff = 1'b1;
              stop = 1'b1;
            end
          end
          wlc_pkg::WcCrDigit: begin
            if (a != cp_t'(cr_digit)) begin
              v.diff = 1'b1;
              stop = 1'b1;
            end
          end
          wlc_pkg::WcUnit: begin
            if (a != wlc_pkg::CpLowerM && a != wlc_pkg::CpLowerN &&
                a != wlc_pkg::CpLowerU && a != wlc_pkg::CpMu) oi--;
          end
          default: begin
            v.diff = 1'b1;
            stop = 1'b1;
          end
        endcase
      end
      if (!stop) p++;
    end
    if (ovf_flag) v.diff = 1'b1;
    v.pos = v.diff ? p[wlc_pkg::LenW-1:0] : '0;
    v.ovf = ovf_flag;
    return v;
  endfunction

  function automatic void apply_transaction(logic [wlc_pkg::FuncW-1:0] f, cp_t cp);
    case (f)
      wlc_pkg::FuncAppendOut: begin
        if (out_cnt < wlc_pkg::MaxLine) begin
          out_chars[out_cnt] = cp;
          out_cnt++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      wlc_pkg::FuncAppendRef: begin
        if (ref_cnt < wlc_pkg::MaxLine) begin
          ref_chars[ref_cnt] = cp;
          ref_cnt++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      wlc_pkg::FuncCompare: begin
        verdict_q.push_back(match_lines());
        out_cnt = 0;
        ref_cnt = 0;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [wlc_pkg::FuncW-1:0] f, input cp_t cp);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= f;
    code_point_i <= cp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_transaction(f, cp);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_cr_digit(input logic [wlc_pkg::CfgW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cr_digit = val;
  endtask

  // loads both lines with the appends interleaved at random, then compares
  task automatic commit_pair();
    int oi;
    int ri;
    oi = 0;
    ri = 0;
    while (oi < out_seq.size() || ri < ref_seq.size()) begin
      if (ri >= ref_seq.size() || (oi < out_seq.size() && $urandom_range(0, 1) == 0)) begin
        send_item(wlc_pkg::FuncAppendOut, out_seq[oi]);
        oi++;
      end else begin
        send_item(wlc_pkg::FuncAppendRef, ref_seq[ri]);
        ri++;
      end
    end
    send_item(wlc_pkg::FuncCompare, cp_t'($urandom_range(0, 1114111)));
  endtask

  function automatic cp_t number_piece();
    case ($urandom_range(0, 6))
      0: return wlc_pkg::CpOverbar;
      1: return wlc_pkg::CpUpperE;
      2: return wlc_pkg::CpUpperJ;
      3: return wlc_pkg::CpDot;
      default: return cp_t'(wlc_pkg::CpZero + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic cp_t pick_char();
    case ($urandom_range(0, 11))
      0, 1: return cp_t'($urandom_range(0, 1114111));
      2: return cp_t'(wlc_pkg::CpZero + $urandom_range(0, 9));
      3: return wlc_pkg::CpSpace;
      4: return number_piece();
      5: return ($urandom_range(0, 1) == 0) ? wlc_pkg::CpPlus : wlc_pkg::CpMinus;
      6: begin
        case ($urandom_range(0, 3))
          0: return wlc_pkg::CpLowerM;
          1: return wlc_pkg::CpLowerN;
          2: return wlc_pkg::CpLowerU;
          default: return wlc_pkg::CpMu;
        endcase
      end
      7: begin
        case ($urandom_range(0, 7))
          0: return wlc_pkg::WcDigits;
          1: return wlc_pkg::WcSpaces;
          2: return wlc_pkg::WcReal;
          3: return wlc_pkg::WcAny;
          4: return wlc_pkg::WcOverbar;
          5: return wlc_pkg::WcSign;
          6: return wlc_pkg::WcCrDigit;
          default: return wlc_pkg::WcUnit;
        endcase
      end
      8: return ($urandom_range(0, 3) == 0) ? wlc_pkg::CpNul : CpA;
      default: return cp_t'(CpA + $urandom_range(0, 25));
    endcase
  endfunction

  task automatic build_random_pair();
    int  n;
    int  idx;
    cp_t c;
    out_seq.delete();
    ref_seq.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, 6);
      repeat (n) out_seq.push_back(pick_char());
      n = $urandom_range(0, 6);
      repeat (n) ref_seq.push_back(pick_char());
      return;
    end
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 10))
        0, 1, 2: begin
          c = pick_char();
          out_seq.push_back(c);
          ref_seq.push_back(c);
        end
        3: begin
          ref_seq.push_back(wlc_pkg::WcDigits);
          repeat ($urandom_range(1, 3)) begin
            out_seq.push_back(cp_t'(wlc_pkg::CpZero + $urandom_range(0, 9)));
          end
        end
        4: begin
          ref_seq.push_back(wlc_pkg::WcSpaces);
          repeat ($urandom_range(1, 3)) out_seq.push_back(wlc_pkg::CpSpace);
        end
        5: begin
          ref_seq.push_back(wlc_pkg::WcReal);
          repeat ($urandom_range(1, 4)) out_seq.push_back(number_piece());
        end
        6: begin
          ref_seq.push_back(wlc_pkg::WcAny);
          repeat ($urandom_range(0, 3)) out_seq.push_back(pick_char());
        end
        7: begin
          ref_seq.push_back(wlc_pkg::WcOverbar);
          if ($urandom_range(0, 1) == 0) out_seq.push_back(wlc_pkg::CpOverbar);
        end
        8: begin
          ref_seq.push_back(wlc_pkg::WcSign);
          out_seq.push_back(($urandom_range(0, 1) == 0) ? wlc_pkg::CpPlus : wlc_pkg::CpMinus);
        end
        9: begin
          ref_seq.push_back(wlc_pkg::WcCrDigit);
          if ($urandom_range(0, 3) == 0) begin
            out_seq.push_back(cp_t'(wlc_pkg::CpZero + $urandom_range(0, 1)));
          end else begin
            out_seq.push_back(cp_t'(cr_digit));
          end
        end
        default: begin
          ref_seq.push_back(wlc_pkg::WcUnit);
          case ($urandom_range(0, 4))
            0: out_seq.push_back(wlc_pkg::CpLowerM);
            1: out_seq.push_back(wlc_pkg::CpLowerN);
            2: out_seq.push_back(wlc_pkg::CpLowerU);
            3: out_seq.push_back(wlc_pkg::CpMu);
            default: ;
          endcase
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0 && out_seq.size() != 0) begin
      idx = $urandom_range(0, out_seq.size() - 1);
      case ($urandom_range(0, 2))
        0: out_seq[idx] = pick_char();
        1: out_seq.delete(idx);
        default: out_seq.insert(idx, pick_char());
      endcase
    end
  endtask

  task automatic test_wildcards();
    out_seq = {};
    ref_seq = {};
    commit_pair();
    out_seq = '{CpOne, CpTwo};
    ref_seq = '{wlc_pkg::WcDigits};
    commit_pair();
    out_seq = '{CpA};
    commit_pair();
    out_seq = '{CpA, wlc_pkg::CpSpace, wlc_pkg::CpSpace, CpB};
    ref_seq = '{CpA, wlc_pkg::WcSpaces, CpB};
    commit_pair();
    out_seq = '{wlc_pkg::CpOverbar, CpOne, wlc_pkg::CpDot, CpFive, wlc_pkg::CpUpperE,
                CpThree, wlc_pkg::CpUpperJ};
    ref_seq = '{wlc_pkg::WcReal};
    commit_pair();
    out_seq = '{CpX, CpY};
    ref_seq = '{CpX, wlc_pkg::WcAny, CpQ};
    commit_pair();
    out_seq = '{wlc_pkg::CpOverbar, CpFive};
    ref_seq = '{wlc_pkg::WcOverbar, wlc_pkg::WcDigits};
    commit_pair();
    out_seq = '{CpFive, wlc_pkg::CpPlus, wlc_pkg::CpMinus, wlc_pkg::CpMu};
    ref_seq = '{wlc_pkg::WcOverbar, wlc_pkg::WcDigits, wlc_pkg::WcSign, wlc_pkg::WcSign,
                wlc_pkg::WcUnit};
    commit_pair();
    out_seq = '{CpX};
    ref_seq = '{wlc_pkg::WcSign};
    commit_pair();
    out_seq = '{wlc_pkg::CpZero, CpOne, wlc_pkg::CpLowerM};
    ref_seq = '{wlc_pkg::WcCrDigit, wlc_pkg::WcCrDigit, wlc_pkg::WcUnit, wlc_pkg::CpLowerM};
    commit_pair();
  endtask

  task automatic test_edge_codes();
    out_seq = '{CpA, wlc_pkg::CpNul, CpB};
    ref_seq = '{CpA};
    commit_pair();
    out_seq = '{CpTop, CpHiMid};
    ref_seq = '{CpTop, CpHiMid};
    commit_pair();
    send_item(FuncIgnored, CpTop);
    out_seq = '{CpB};
    ref_seq = '{CpA};
    commit_pair();
    drain();
  endtask

  task automatic test_cr_digit();
    set_cr_digit(6'd49);
    out_seq = '{CpOne};
    ref_seq = '{wlc_pkg::WcCrDigit};
    commit_pair();
    out_seq = '{wlc_pkg::CpZero};
    commit_pair();
    set_cr_digit(6'd48);
  endtask

  // both lines fill up and then each drops one appended character
  task automatic test_line_limits();
    out_seq.delete();
    ref_seq.delete();
    repeat (wlc_pkg::MaxLine + 1) out_seq.push_back(CpA);
    repeat (wlc_pkg::MaxLine + 1) ref_seq.push_back(CpA);
    commit_pair();
    drain();
  endtask

  task automatic test_random(input int n_items, input int idle);
    int goal;
    idle_pct = idle;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      build_random_pair();
      commit_pair();
    end
    drain();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    func_i       <= wlc_pkg::FuncAppendOut;
    code_point_i <= wlc_pkg::CpNul;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= wlc_pkg::CrDigitReset;
    items_sent   = 0;
    results_seen = 0;
    errors       = 0;
    idle_pct     = 0;
    out_cnt      = 0;
    ref_cnt      = 0;
    ovf_flag     = 1'b0;
    cr_digit     = wlc_pkg::CrDigitReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wildcards();
    test_edge_codes();
    test_cr_digit();
    idle_pct = 50;
    test_line_limits();
    idle_pct = 0;

    set_cr_digit(6'd48);
    test_random(80, 0);
    set_cr_digit(6'd49);
    test_random(80, 50);
    set_cr_digit(6'd63);
    test_random(50, 38);
    set_cr_digit(6'd0);
    test_random(50, 38);
    set_cr_digit(6'd48);
    test_random(40, 0);

    drain();
    repeat (20) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $display("%0d compare results never arrived", verdict_q.size());
      errors++;
    end
    $display("summary: %0d transactions accepted, %0d compare results checked, %0d errors",
             items_sent, results_seen, errors);
    $display("summary: all wildcards, full and overflowing lines, digit settings 48 49 63 0");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
